[hdl/cdma_pkg.sv]
// Shared constants and types for the clap detector (moving average threshold).
// No dependencies; the interfaces, the detector and the bench import this package.
`timescale 1ns / 1ps

package cdma_pkg;

	// ring geometry
	localparam int WINDOW = 50;
	localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W  = $clog2(WINDOW + 1);

	// field widths
	localparam int LEVEL_W    = 12;
	localparam int TIME_W     = 32;
	localparam int DIFF_W     = 12;
	localparam int INTERVAL_W = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// arithmetic widths: sum of the window, products of a 12-bit value and the fill count
	localparam int SUM_W  = LEVEL_W + CNT_W;
	localparam int PROD_W = LEVEL_W + CNT_W;
	localparam int RHS_W  = SUM_W + 1;

	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);
	localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(WINDOW);

	// configuration register reset values
	localparam logic [DIFF_W-1:0]     LOUD_DIFF_RST    = DIFF_W'(160);
	localparam logic [INTERVAL_W-1:0] INTERVAL_MIN_RST = INTERVAL_W'(100);
	localparam logic [INTERVAL_W-1:0] INTERVAL_MAX_RST = INTERVAL_W'(1000);

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOUD_DIFF    = 2'd0,
		REG_INTERVAL_MIN = 2'd1,
		REG_INTERVAL_MAX = 2'd2
	} cfg_reg_t;

endpackage

[hdl/cdma_ifs.sv]
// Channel interfaces of the clap detector: sample in, result out, configuration write.
// Depends on cdma_pkg.
`timescale 1ns / 1ps

interface sample_if import cdma_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               mode;
	logic [LEVEL_W-1:0] level;
	logic [TIME_W-1:0]  time_ms;

	modport source (output valid, output mode, output level, output time_ms, input ready);
	modport sink (input valid, input mode, input level, input time_ms, output ready);
endinterface

interface result_if ();
	logic valid;
	logic ready;
	logic loud;
	logic clap;

	modport source (output valid, output loud, output clap, input ready);
	modport sink (input valid, input loud, input clap, output ready);
endinterface

interface cfg_if import cdma_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/cdma_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module cdma_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port, holds between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hdl/clap_detector_moving_average.sv]
// A sample passes through stage 1, where the ring memory read of the evicted entry comes
// ahead of the sum update, and then the result register before its result is presented.
// Throughput: one sample per cycle while results are taken; a held result stalls input only
// once stage 1 is full.
// Reset (arst_n low): sum, fill count, slot and loud history clear, registers take defaults;
// the ring memory is not cleared and its read data is used only once every entry has been written.
// Depends on cdma_pkg, cdma_ifs and cdma_ram.
`timescale 1ns / 1ps

module clap_detector_moving_average import cdma_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	sample_if.sink  sample,
	result_if.source result,
	cfg_if.sink     cfg
);

	// configuration registers
	logic [DIFF_W-1:0]     loud_diff_q;
	logic [INTERVAL_W-1:0] interval_min_q;
	logic [INTERVAL_W-1:0] interval_max_q;

	// window state
	logic [SLOT_W-1:0] slot_q;
	logic [CNT_W-1:0]  fill_q;
	logic [SUM_W-1:0]  sum_q;
	logic [TIME_W-1:0] last_loud_q;
	logic              have_last_q;

	// stage 1
	logic               valid_s1;
	logic               mode_s1;
	logic [LEVEL_W-1:0] level_s1;
	logic [TIME_W-1:0]  time_s1;
	logic [SLOT_W-1:0]  slot_s1;
	logic               fwd_s1;
	logic [LEVEL_W-1:0] fwd_level_s1;

	// result register
	logic res_valid_q;
	logic loud_q;
	logic clap_q;

	logic               accept;
	logic               fire;
	logic [LEVEL_W-1:0] ram_rdata;
	logic [LEVEL_W-1:0] evict;
	logic               full;
	logic [PROD_W-1:0]  lhs;
	logic [PROD_W-1:0]  diff_prod;
	logic [RHS_W-1:0]   rhs;
	logic               loud;
	logic [TIME_W-1:0]  gap;
	logic               clap;
	logic [SUM_W-1:0]   sum_next;

	// handshakes
	assign accept       = sample.valid && sample.ready;
	assign fire         = valid_s1 && (!res_valid_q || result.ready);
	assign sample.ready = !valid_s1 || fire;
	assign cfg.ready    = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loud_diff_q    <= LOUD_DIFF_RST;
			interval_min_q <= INTERVAL_MIN_RST;
			interval_max_q <= INTERVAL_MAX_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_LOUD_DIFF:    loud_diff_q    <= cfg.data[DIFF_W-1:0];
				REG_INTERVAL_MIN: interval_min_q <= cfg.data[INTERVAL_W-1:0];
				REG_INTERVAL_MAX: interval_max_q <= cfg.data[INTERVAL_W-1:0];
				default: ;
			endcase
		end
	end

	// level ring: read the slot to evict on transfer, write the new level when stage 1 retires
	cdma_ram #(
		.WIDTH(LEVEL_W),
		.DEPTH(WINDOW)
	) u_ring (
		.clk   (clk),
		.we    (fire),
		.waddr (slot_s1),
		.wdata (level_s1),
		.re    (accept),
		.raddr (slot_q),
		.rdata (ram_rdata)
	);

	// write slot advances on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (accept) begin
			slot_q <= (slot_q == SLOT_LAST) ? '0 : slot_q + SLOT_W'(1);
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage 1 payload, with forwarding when the read hits the slot written in the same cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1      <= sample.mode;
			level_s1     <= sample.level;
			time_s1      <= sample.time_ms;
			slot_s1      <= slot_q;
			fwd_s1       <= fire && (slot_s1 == slot_q);
			fwd_level_s1 <= level_s1;
		end
	end

	// loud test: level*n > sum + diff*n
	assign evict     = fwd_s1 ? fwd_level_s1 : ram_rdata;
	assign full      = (fill_q == CNT_FULL);
	assign lhs       = PROD_W'(level_s1) * PROD_W'(fill_q);
	assign diff_prod = PROD_W'(loud_diff_q) * PROD_W'(fill_q);
	assign rhs       = RHS_W'(sum_q) + RHS_W'(diff_prod);
	assign loud      = mode_s1 && (fill_q != '0) && (RHS_W'(lhs) > rhs);

	// gap since previous loud sample, modulo 2^32
	assign gap  = time_s1 - last_loud_q;
	assign clap = loud && have_last_q
		&& (gap >= TIME_W'(interval_min_q)) && (gap <= TIME_W'(interval_max_q));

	// running sum: drop the evicted level once the window is full
	assign sum_next = sum_q - (full ? SUM_W'(evict) : '0) + SUM_W'(level_s1);

	// window state update on retire
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			sum_q       <= '0;
			last_loud_q <= '0;
			have_last_q <= 1'b0;
		end else if (fire) begin
			sum_q <= sum_next;
			if (!full) begin
				fill_q <= fill_q + CNT_W'(1);
			end
			if (loud) begin
				last_loud_q <= time_s1;
				have_last_q <= 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			loud_q <= loud;
			clap_q <= clap;
		end
	end

	assign result.valid = res_valid_q;
	assign result.loud  = loud_q;
	assign result.clap  = clap_q;

endmodule

[hdl/cdma_checker.sv]
// Port-level assertions for the clap detector, attached to the top level by bind.
// Depends on clap_detector_moving_average.
`timescale 1ns / 1ps

module cdma_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic out_loud,
	input logic out_clap
);

	logic in_xfer;

	assign in_xfer = in_valid && in_ready;

	// a pending result stays until transferred
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before transfer");

	// a clap is always a loud sample
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!out_clap || out_loud))
		else $error("clap flagged without loud");

	// a new result needs a sample transfer through stage 1 and the result register, or an already pending result
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ($past(out_valid) || $past(in_xfer, 2)))
		else $error("result without a matching sample");

	// with no result pending and stage 1 drained the block takes a sample
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && !$past(in_xfer) |-> in_ready)
		else $error("input stalled while empty");

endmodule

bind clap_detector_moving_average cdma_checker u_cdma_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample.valid),
	.in_ready  (sample.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_loud  (result.loud),
	.out_clap  (result.clap)
);

[tb/testbench.sv]
// Self-checking bench for the clap detector: sample, result and register write channels.
// Depends on cdma_pkg, cdma_ifs and the clap_detector_moving_average top level.
`timescale 1ns / 1ps

module testbench;
	import cdma_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES  = 4;
	localparam int DRAIN_CYCLES   = 20;
	localparam int CALM_ITEMS     = 60;
	localparam int WATCHDOG_LIMIT = 1000;

	typedef struct packed {
		logic                  is_write;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
		logic                  mode;
		logic [LEVEL_W-1:0]    level;
		logic [TIME_W-1:0]     stamp;
	} bench_op_t;

	typedef struct packed {
		logic loud;
		logic clap;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// values the bench puts on the block inputs
	logic                  drv_valid = 1'b0;
	logic                  drv_mode = 1'b0;
	logic [LEVEL_W-1:0]    drv_level = '0;
	logic [TIME_W-1:0]     drv_stamp = '0;
	logic                  wr_valid = 1'b0;
	logic [CFG_IDX_W-1:0]  wr_index = '0;
	logic [CFG_DATA_W-1:0] wr_data = '0;
	logic                  take_ready = 1'b0;

	bench_op_t op_q[$];
	verdict_t  verdict_q[$];
	int        outstanding = 0;
	logic      calm = 1'b0;
	int        errors = 0;
	int        samples_seen = 0;
	int        louds_seen = 0;
	int        claps_seen = 0;
	int        writes_seen = 0;
	int        quiet_cycles = 0;

	// detector state as the bench tracks it
	logic [LEVEL_W-1:0]    model_ring [WINDOW];
	logic [SLOT_W-1:0]     model_slot = '0;
	logic [CNT_W-1:0]      model_fill = '0;
	logic [SUM_W-1:0]      model_sum = '0;
	logic [TIME_W-1:0]     model_last_loud = '0;
	logic                  model_seen_loud = 1'b0;
	logic [DIFF_W-1:0]     model_margin = LOUD_DIFF_RST;
	logic [INTERVAL_W-1:0] model_gap_min = INTERVAL_MIN_RST;
	logic [INTERVAL_W-1:0] model_gap_max = INTERVAL_MAX_RST;

	sample_if sample_ch ();
	result_if result_ch ();
	cfg_if    cfg_ch ();

	assign sample_ch.valid   = drv_valid;
	assign sample_ch.mode    = drv_mode;
	assign sample_ch.level   = drv_level;
	assign sample_ch.time_ms = drv_stamp;
	assign cfg_ch.valid      = wr_valid;
	assign cfg_ch.index      = wr_index;
	assign cfg_ch.data       = wr_data;
	assign result_ch.ready   = take_ready;

	clap_detector_moving_average dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	always #5 clk = ~clk;

	// loudness and clap decision for one sample, then ring update
	function automatic verdict_t judge_sample(input logic mode, input logic [LEVEL_W-1:0] lvl,
			input logic [TIME_W-1:0] stamp);
		verdict_t    v;
		logic [31:0] lhs;
		logic [31:0] rhs;
		logic [31:0] gap;
		v = '0;
		if (mode && model_fill != '0) begin
			lhs = 32'(lvl) * 32'(model_fill);
			rhs = 32'(model_sum) + 32'(model_margin) * 32'(model_fill);
			v.loud = (lhs > rhs);
		end
		if (v.loud) begin
			gap = stamp - model_last_loud;
			v.clap = model_seen_loud && gap >= 32'(model_gap_min) && gap <= 32'(model_gap_max);
			model_last_loud = stamp;
			model_seen_loud = 1'b1;
		end
		// full window: drop the oldest level before overwriting it
		if (model_fill == CNT_FULL) begin
			model_sum = model_sum - SUM_W'(model_ring[model_slot]);
		end else begin
			model_fill = model_fill + CNT_W'(1);
		end
		model_ring[model_slot] = lvl;
		model_sum = model_sum + SUM_W'(lvl);
		model_slot = (model_slot == SLOT_LAST) ? '0 : model_slot + SLOT_W'(1);
		return v;
	endfunction

	function automatic void apply_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_LOUD_DIFF: begin
				model_margin = data[DIFF_W-1:0];
			end
			REG_INTERVAL_MIN: begin
				model_gap_min = data[INTERVAL_W-1:0];
			end
			REG_INTERVAL_MAX: begin
				model_gap_max = data[INTERVAL_W-1:0];
			end
			default: begin
			end
		endcase
	endfunction

	function automatic logic [LEVEL_W-1:0] fit_level(input int v);
		if (v < 0) return '0;
		if (v > 4095) return '1;
		return LEVEL_W'(v);
	endfunction

	task automatic add_sample(input logic mode, input logic [LEVEL_W-1:0] lvl,
			input logic [TIME_W-1:0] stamp);
		bench_op_t op;
		op = '0;
		op.mode = mode;
		op.level = lvl;
		op.stamp = stamp;
		op_q.push_back(op);
	endtask

	task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		bench_op_t op;
		op = '0;
		op.is_write = 1'b1;
		op.index = idx;
		op.data = data;
		op_q.push_back(op);
	endtask

	// one setting, a quiet background with loud spikes at chosen gaps, plus some noise
	task automatic queue_scene(input logic [CFG_DATA_W-1:0] margin_word,
			input logic [INTERVAL_W-1:0] gmin, input logic [INTERVAL_W-1:0] gmax,
			input int count, input logic [TIME_W-1:0] start);
		logic [TIME_W-1:0] now;
		logic [TIME_W-1:0] spike_at;
		logic [TIME_W-1:0] span;
		int base;
		int margin;
		int jitter;
		int k;
		margin = int'(margin_word[DIFF_W-1:0]);
		add_write(REG_LOUD_DIFF, margin_word);
		add_write(REG_INTERVAL_MIN, gmin);
		add_write(REG_INTERVAL_MAX, gmax);
		now = start;
		spike_at = start;
		base = $urandom_range(0, 2800);
		// a short calibration run at the top of the scene
		repeat ($urandom_range(0, 6)) begin
			jitter = $urandom_range(0, 40);
			add_sample(1'b0, fit_level(base + jitter - 20), now);
			now = now + 32'($urandom_range(1, 40));
		end
		for (k = 0; k < count; k++) begin
			case ($urandom_range(0, 9))
				0: begin
					add_sample(1'($urandom), 12'($urandom), $urandom);
				end
				1, 2: begin
					case ($urandom_range(0, 5))
						0: span = 32'(gmin) - 32'd1;
						1: span = 32'(gmin);
						2: span = 32'(gmax);
						3: span = 32'(gmax) + 32'd1;
						4: span = 32'($urandom_range(gmin, gmax));
						default: span = 32'($urandom_range(0, 70000));
					endcase
					spike_at = spike_at + span;
					jitter = $urandom_range(0, 420);
					add_sample(1'b1, fit_level(base + margin + jitter - 20), spike_at);
					now = spike_at;
				end
				default: begin
					jitter = $urandom_range(0, 60);
					add_sample(($urandom_range(0, 9) != 0), fit_level(base + jitter - 30), now);
					now = now + 32'($urandom_range(1, 40));
				end
			endcase
		end
	endtask

	// driver: samples and register writes from the pending queue
	always @(posedge clk) begin : feed
		logic s_busy;
		logic c_busy;
		logic nxt_sv;
		logic nxt_cv;
		logic smooth;
		int gap_left;
		int settle;
		int unsigned drv_cycle;
		bench_op_t op;
		if (arst_n) begin
			drv_cycle = drv_cycle + 1;
			smooth = (drv_cycle[8:7] == 2'b11);
			s_busy = drv_valid && !sample_ch.ready;
			c_busy = wr_valid && !cfg_ch.ready;
			nxt_sv = s_busy;
			nxt_cv = c_busy;
			// count idle cycles with nothing left in flight
			if (outstanding == 0 && !drv_valid && !wr_valid) begin
				settle = settle + 1;
			end else begin
				settle = 0;
			end
			if (!s_busy && !c_busy) begin
				if (gap_left > 0) begin
					gap_left = gap_left - 1;
				end else if (op_q.size() != 0) begin
					if (op_q[0].is_write) begin
						if (settle >= SETTLE_CYCLES) begin
							op = op_q.pop_front();
							nxt_cv = 1'b1;
							wr_index <= op.index;
							wr_data <= op.data;
							settle = 0;
						end
					end else begin
						op = op_q.pop_front();
						nxt_sv = 1'b1;
						drv_mode <= op.mode;
						drv_level <= op.level;
						drv_stamp <= op.stamp;
						if (!calm && !smooth && $urandom_range(0, 5) == 0) begin
							gap_left = $urandom_range(1, 15);
						end
					end
				end
			end
			drv_valid <= nxt_sv;
			wr_valid <= nxt_cv;
			calm <= (op_q.size() < CALM_ITEMS);
		end else begin
			gap_left = 0;
			settle = 0;
			drv_cycle = 0;
		end
	end

	// monitor: predict on input transfers, check on result transfers, stall the result side
	always @(posedge clk) begin : watch
		verdict_t want;
		verdict_t got;
		logic nxt_ready;
		logic smooth;
		int stall_left;
		int unsigned mon_cycle;
		if (arst_n) begin
			mon_cycle = mon_cycle + 1;
			smooth = (mon_cycle[9:8] == 2'b00);
			if (sample_ch.valid && sample_ch.ready) begin
				verdict_q.push_back(judge_sample(sample_ch.mode, sample_ch.level, sample_ch.time_ms));
				samples_seen++;
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				apply_write(cfg_ch.index, cfg_ch.data);
				writes_seen++;
			end
			if (result_ch.valid && result_ch.ready) begin
				got.loud = result_ch.loud;
				got.clap = result_ch.clap;
				if (verdict_q.size() == 0) begin
					$display("%0t: result transfer with nothing expected, actual loud %0b clap %0b",
						$time, got.loud, got.clap);
					errors++;
				end else begin
					want = verdict_q.pop_front();
					if (got.loud !== want.loud) begin
						$display("%0t: loud mismatch, expected %0b, actual %0b",
							$time, want.loud, got.loud);
						errors++;
					end
					if (got.clap !== want.clap) begin
						$display("%0t: clap mismatch, expected %0b, actual %0b",
							$time, want.clap, got.clap);
						errors++;
					end
					louds_seen += want.loud;
					claps_seen += want.clap;
				end
			end
			// random back-pressure bursts on the result side
			if (stall_left > 0) begin
				stall_left = stall_left - 1;
				nxt_ready = 1'b0;
			end else begin
				nxt_ready = 1'b1;
				if (!calm && !smooth && $urandom_range(0, 7) == 0) begin
					stall_left = $urandom_range(1, 15);
					nxt_ready = 1'b0;
				end
			end
			take_ready <= nxt_ready;
			outstanding <= verdict_q.size();
		end else begin
			stall_left = 0;
			mon_cycle = 0;
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (sample_ch.valid && sample_ch.ready) || (cfg_ch.valid && cfg_ch.ready)
				|| (result_ch.valid && result_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog, no transfer for %0d cycles", $time, quiet_cycles);
			$display("Some tests failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		int s;

		// empty window, then calibration, loud runs around the gap limits and a time wrap
		add_sample(1'b1, 12'hFFF, 32'd5);
		add_sample(1'b0, 12'h000, 32'd10);
		add_sample(1'b0, 12'h000, 32'd20);
		add_sample(1'b0, 12'h000, 32'd30);
		add_sample(1'b1, 12'hFFF, 32'd1000);
		add_sample(1'b1, 12'hFFF, 32'd1099);
		add_sample(1'b1, 12'hFFF, 32'd1199);
		add_sample(1'b1, 12'hFFF, 32'd2199);
		add_sample(1'b1, 12'hFFF, 32'd3200);
		add_sample(1'b0, 12'hFFF, 32'd3300);
		add_sample(1'b1, 12'h000, 32'd3400);
		add_sample(1'b1, 12'hFFF, 32'hFFFF_FF00);
		add_sample(1'b1, 12'hFFF, 32'h0000_00A0);
		// unknown register index is dropped
		add_write(REG_UNUSED, 16'hFFFF);
		add_sample(1'b1, 12'hFFF, 32'h0000_0200);
		// margin write keeps only its low bits, both interval limits at their maximum
		add_write(REG_LOUD_DIFF, 16'hF000);
		add_write(REG_INTERVAL_MIN, 16'hFFFF);
		add_write(REG_INTERVAL_MAX, 16'hFFFF);
		add_sample(1'b1, 12'hFFF, 32'h0001_01FF);
		add_sample(1'b1, 12'hA5A, 32'h0001_0300);
		add_sample(1'b1, 12'h5A5, 32'h0001_0400);

		// random scenes through several settings, extremes first
		queue_scene(16'd160, 16'd100, 16'd1000, 115, $urandom);
		queue_scene(16'h0000, 16'd0, 16'hFFFF, 115, $urandom);
		queue_scene(16'hFFFF, 16'd0, 16'd0, 60, $urandom);
		queue_scene(16'($urandom_range(0, 400)), 16'd300, 16'd300, 115,
			32'hFFFF_FFFF - 32'($urandom_range(0, 2000)));
		queue_scene(16'd100, 16'd2000, 16'd500, 115, $urandom);
		for (s = 0; s < 3; s++) begin
			queue_scene({4'($urandom), 12'($urandom_range(0, 600))},
				16'($urandom_range(0, 1500)), 16'($urandom_range(0, 3000)), 115, $urandom);
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// wait for the queue to empty and every result to come back
		do begin
			@(posedge clk);
		end while (op_q.size() != 0 || drv_valid || wr_valid || outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (verdict_q.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, verdict_q.size());
			errors++;
		end
		$display("covered %0d samples with %0d loud and %0d claps predicted", samples_seen,
			louds_seen, claps_seen);
		$display("register writes applied across settings: %0d", writes_seen);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
